>>> src/okl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okl_pkg
// Shared types and codes for the ordered key list.
// ----------------------------------------------------------------------------
package okl_pkg;

   localparam int DEPTH_DEFAULT    = 64;
   localparam int KEY_BITS_DEFAULT = 32;

   localparam int KEY_W      = 32;
   localparam int COMMAND_W  = 2;
   localparam int STATUS_W   = 2;
   localparam int POSITION_W = 6;
   localparam int COUNT_W    = 7;

   localparam logic [COMMAND_W-1:0] CMD_APPEND = 2'd0;
   localparam logic [COMMAND_W-1:0] CMD_SEARCH = 2'd1;
   localparam logic [COMMAND_W-1:0] CMD_DELETE = 2'd2;
   localparam logic [COMMAND_W-1:0] CMD_CLEAR  = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_MISS = 2'd2;

   typedef struct packed {
      logic [COMMAND_W-1:0]    command;
      logic signed [KEY_W-1:0] key;
   } okl_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [POSITION_W-1:0] position;
      logic [COUNT_W-1:0]    count;
   } okl_rsp_type;

endpackage

>>> src/okl_key_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okl_key_ram
// Key storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module okl_key_ram #(
   parameter int DEPTH    = okl_pkg::DEPTH_DEFAULT,
   parameter int KEY_BITS = okl_pkg::KEY_BITS_DEFAULT,
   localparam int ADDR_W  = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  logic [KEY_BITS-1:0] wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output logic [KEY_BITS-1:0] rd_data
);
   import okl_pkg::*;

   logic [KEY_BITS-1:0] mem [DEPTH];
   logic [KEY_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/okl_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okl_seq
// Command sequencer: appends, clears, scans the store for a key, closes the gap
// after a delete and keeps the entry count.
// ----------------------------------------------------------------------------
module okl_seq #(
   parameter int DEPTH    = okl_pkg::DEPTH_DEFAULT,
   parameter int KEY_BITS = okl_pkg::KEY_BITS_DEFAULT,
   localparam int ADDR_W  = $clog2(DEPTH),
   localparam int CNT_W   = $clog2(DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  okl_pkg::okl_req_type  req_data,
   output logic                  res_valid,
   input  logic                  res_ready,
   output okl_pkg::okl_rsp_type  res_data,
   output logic                  wr_en,
   output logic [ADDR_W-1:0]     wr_addr,
   output logic [KEY_BITS-1:0]   wr_data,
   output logic [ADDR_W-1:0]     rd_addr,
   input  logic [KEY_BITS-1:0]   rd_data
);
   import okl_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_SHIFT = 4'b0100,
      S_RESP  = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [ADDR_W-1:0]     idx_ff, idx_in;
   logic [COMMAND_W-1:0]  cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [ADDR_W-1:0]     pos_ff, pos_in;

   logic                  accept;
   logic [KEY_BITS-1:0]   req_key;
   logic [CNT_W-1:0]      idx_next;
   logic                  match;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign req_key   = KEY_BITS'($unsigned(req_data.key));
   assign idx_next  = CNT_W'(idx_ff) + CNT_W'(1);
   assign match     = (rd_data == key_ff);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      cmd_in    = cmd_ff;
      key_in    = key_ff;
      status_in = status_ff;
      pos_in    = pos_ff;
      rd_addr   = '0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = rd_data;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in    = req_data.command;
               key_in    = req_key;
               status_in = STAT_OK;
               pos_in    = '0;
               state_in  = S_RESP;
               case (req_data.command)
                  CMD_APPEND: begin
                     if (count_ff >= CNT_W'(DEPTH)) begin
                        status_in = STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[ADDR_W-1:0];
                        wr_data  = req_key;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_SEARCH, CMD_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = STAT_MISS;
                     end else begin
                        rd_addr  = '0;
                        idx_in   = '0;
                        state_in = S_SCAN;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (match) begin
               if (cmd_ff == CMD_SEARCH) begin
                  pos_in   = idx_ff;
                  state_in = S_RESP;
               end else if (idx_next < count_ff) begin
                  rd_addr  = ADDR_W'(idx_next);
                  idx_in   = ADDR_W'(idx_next);
                  state_in = S_SHIFT;
               end else begin
                  count_in = count_ff - CNT_W'(1);
                  state_in = S_RESP;
               end
            end else if (idx_next >= count_ff) begin
               status_in = STAT_MISS;
               state_in  = S_RESP;
            end else begin
               rd_addr = ADDR_W'(idx_next);
               idx_in  = ADDR_W'(idx_next);
            end
         end
         S_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff - ADDR_W'(1);
            wr_data = rd_data;
            if (idx_next < count_ff) begin
               rd_addr = ADDR_W'(idx_next);
               idx_in  = ADDR_W'(idx_next);
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      pos_ff    <= pos_in;
   end

   assign res_valid         = (state_ff == S_RESP);
   assign res_data.status   = status_ff;
   assign res_data.position = POSITION_W'(pos_ff);
   assign res_data.count    = COUNT_W'(count_ff);

   // count never exceeds capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above capacity");

   // scanning only within the filled part of the store
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN || state_ff == S_SHIFT) |-> (CNT_W'(idx_ff) < count_ff))
      else $error("scan index outside filled entries");

   // writes stay at or below the tail
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CNT_W'(wr_addr) <= count_ff))
      else $error("store write beyond tail");

   // a shift step writes one place below the read it consumes
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (cmd_ff == CMD_DELETE && idx_ff != '0))
      else $error("shift outside a delete");

   // reset returns the sequencer to idle
   assert property (@(posedge clock)
      reset |=> (state_ff == S_IDLE && count_ff == '0))
      else $error("sequencer not idle after reset");

endmodule

>>> src/ordered_key_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_key_list
// Bounded list of keys in insertion order with append, search, delete of the
// first match and clear.
// ----------------------------------------------------------------------------
// One request is worked at a time. Append and clear, and search or delete on
// an empty list, reach the output through the sequencer's response state and
// then the output register. Search and delete walk the key memory through its
// single read port, one entry per cycle, and a delete closes the gap with one
// read-and-write per moved entry. A result waiting in the output register
// does not hold off acceptance of the next request. The key memory needs no
// clearing after reset; the entry count alone marks which entries are live.
module ordered_key_list #(
   parameter int DEPTH    = okl_pkg::DEPTH_DEFAULT,
   parameter int KEY_BITS = okl_pkg::KEY_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  okl_pkg::okl_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output okl_pkg::okl_rsp_type rsp_data
);
   import okl_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [KEY_BITS-1:0] wr_data;
   logic [ADDR_W-1:0]   rd_addr;
   logic [KEY_BITS-1:0] rd_data;

   logic                res_valid;
   logic                res_ready;
   okl_rsp_type         res_data;

   logic                rsp_valid_ff, rsp_valid_in;
   okl_rsp_type         rsp_data_ff, rsp_data_in;

   okl_key_ram #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   okl_seq #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   // output register
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         rsp_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for ordered_key_list. A short directed table covers the
// empty list, extreme keys, duplicates, a full list and clear. Random
// scenarios follow: fills, mixed traffic and drains over a small key pool,
// plus noise. Responses are checked against an in-bench list predictor (fixed
// rows against the table's own response), under random sender bursts and receiver stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
   import okl_pkg::*;

   localparam int RANDOM_ITEMS = 1100;
   localparam int POOL_SIZE    = 16;
   localparam int DRAIN_CYCLES = DEPTH_DEFAULT + 8;

   typedef struct packed {
      logic [COMMAND_W-1:0] command;
      logic [KEY_W-1:0]     key;
      logic [6:0]           reps;
      logic                 fixed;
      okl_rsp_type          rsp;
   } row_type;

   typedef struct packed {
      okl_req_type req;
      logic        fixed;
      okl_rsp_type rsp;
   } list_op_type;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   okl_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   okl_rsp_type rsp_data;

   row_type directed_rows [25] = '{
      '{CMD_SEARCH, 32'h0000_0000, 7'd1, 1'b1, '{STAT_MISS, 6'd0, 7'd0}},
      '{CMD_DELETE, 32'h0000_0005, 7'd1, 1'b1, '{STAT_MISS, 6'd0, 7'd0}},
      '{CMD_CLEAR,  32'hAAAA_AAAA, 7'd1, 1'b1, '{STAT_OK,   6'd0, 7'd0}},
      '{CMD_APPEND, 32'h8000_0000, 7'd1, 1'b1, '{STAT_OK,   6'd0, 7'd1}},
      '{CMD_APPEND, 32'h7FFF_FFFF, 7'd1, 1'b1, '{STAT_OK,   6'd0, 7'd2}},
      '{CMD_APPEND, 32'h0000_0000, 7'd1, 1'b1, '{STAT_OK,   6'd0, 7'd3}},
      '{CMD_APPEND, 32'hFFFF_FFFF, 7'd1, 1'b1, '{STAT_OK,   6'd0, 7'd4}},
      '{CMD_APPEND, 32'h7FFF_FFFF, 7'd1, 1'b1, '{STAT_OK,   6'd0, 7'd5}},
      '{CMD_SEARCH, 32'h7FFF_FFFF, 7'd1, 1'b1, '{STAT_OK,   6'd1, 7'd5}},
      '{CMD_SEARCH, 32'hFFFF_FFFF, 7'd1, 1'b1, '{STAT_OK,   6'd3, 7'd5}},
      '{CMD_SEARCH, 32'h0001_2345, 7'd1, 1'b1, '{STAT_MISS, 6'd0, 7'd5}},
      '{CMD_DELETE, 32'h7FFF_FFFF, 7'd1, 1'b0, '{STAT_OK,   6'd0, 7'd0}},
      '{CMD_SEARCH, 32'h7FFF_FFFF, 7'd1, 1'b0, '{STAT_OK,   6'd0, 7'd0}},
      '{CMD_DELETE, 32'h8000_0000, 7'd1, 1'b0, '{STAT_OK,   6'd0, 7'd0}},
      '{CMD_SEARCH, 32'h0000_0000, 7'd1, 1'b0, '{STAT_OK,   6'd0, 7'd0}},
      '{CMD_DELETE, 32'h55AA_55AA, 7'd1, 1'b0, '{STAT_OK,   6'd0, 7'd0}},
      '{CMD_CLEAR,  32'h5555_5555, 7'd1, 1'b1, '{STAT_OK,   6'd0, 7'd0}},
      '{CMD_SEARCH, 32'h0000_0000, 7'd1, 1'b1, '{STAT_MISS, 6'd0, 7'd0}},
      '{CMD_APPEND, 32'h0000_0400, 7'd64, 1'b0, '{STAT_OK,  6'd0, 7'd0}},
      '{CMD_APPEND, 32'h0000_002A, 7'd1, 1'b1, '{STAT_FULL, 6'd0, 7'd64}},
      '{CMD_SEARCH, 32'h0000_043F, 7'd1, 1'b1, '{STAT_OK,   6'd63, 7'd64}},
      '{CMD_DELETE, 32'h0000_0400, 7'd1, 1'b0, '{STAT_OK,   6'd0, 7'd0}},
      '{CMD_APPEND, 32'h0000_002A, 7'd1, 1'b0, '{STAT_OK,   6'd0, 7'd0}},
      '{CMD_SEARCH, 32'h0000_002A, 7'd1, 1'b0, '{STAT_OK,   6'd0, 7'd0}},
      '{CMD_CLEAR,  32'h0000_0000, 7'd1, 1'b1, '{STAT_OK,   6'd0, 7'd0}}
   };

   list_op_type      op_plan [$];
   okl_rsp_type      pending_results [$];
   logic [KEY_W-1:0] key_pool [POOL_SIZE];

   // predicted list contents
   logic [KEY_W-1:0] list_keys [DEPTH_DEFAULT];
   int               list_len = 0;

   int accepted_items = 0;
   int mismatches     = 0;
   int send_idx       = 0;
   int burst_left     = 1;
   int gap_left       = 0;
   int stall_left     = 0;
   int stall_mode     = 0;
   int stall_period   = 1;
   int stall_phase    = 0;

   ordered_key_list dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

   function automatic okl_rsp_type list_apply(okl_req_type r);
      okl_rsp_type res;
      int          hit;
      res.status   = STAT_OK;
      res.position = '0;
      hit          = -1;
      if (r.command == CMD_SEARCH || r.command == CMD_DELETE) begin
         for (int i = 0; i < list_len; i++) begin
            if (hit < 0 && list_keys[i] == r.key) begin
               hit = i;
            end
         end
      end
      case (r.command)
         CMD_APPEND: begin
            if (list_len >= DEPTH_DEFAULT) begin
               res.status = STAT_FULL;
            end else begin
               list_keys[list_len] = r.key;
               list_len++;
            end
         end
         CMD_SEARCH: begin
            if (hit < 0) begin
               res.status = STAT_MISS;
            end else begin
               res.position = POSITION_W'(hit);
            end
         end
         CMD_DELETE: begin
            if (hit < 0) begin
               res.status = STAT_MISS;
            end else begin
               for (int i = hit; i + 1 < list_len; i++) begin
                  list_keys[i] = list_keys[i + 1];
               end
               list_len--;
            end
         end
         default: begin
            list_len = 0;
         end
      endcase
      res.count = COUNT_W'(list_len);
      return res;
   endfunction

   function automatic void add_op(logic [COMMAND_W-1:0] cmd, logic [KEY_W-1:0] key,
                                  logic fixed, okl_rsp_type rsp);
      list_op_type op;
      op.req.command = cmd;
      op.req.key     = key;
      op.fixed       = fixed;
      op.rsp         = rsp;
      op_plan.push_back(op);
   endfunction

   function automatic logic [KEY_W-1:0] fresh_key();
      logic [KEY_W-1:0] k;
      k = $urandom;
      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 3))
            0:       k = 32'h8000_0000;
            1:       k = 32'h7FFF_FFFF;
            2:       k = 32'h0000_0000;
            default: k = 32'hFFFF_FFFF;
         endcase
      end
      return k;
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(0, 9) < 8) begin
         return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      end
      return fresh_key();
   endfunction

   // stimulus plan, then reset, then wait for the last response
   initial begin
      int random_base;
      int n;
      int roll;
      for (int r = 0; r < 25; r++) begin
         for (int i = 0; i < directed_rows[r].reps; i++) begin
            add_op(directed_rows[r].command, directed_rows[r].key + i,
                   directed_rows[r].fixed, directed_rows[r].rsp);
         end
      end
      for (int i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = fresh_key();
      end
      random_base = op_plan.size();
      while (op_plan.size() < random_base + RANDOM_ITEMS) begin
         for (int i = $urandom_range(0, 4); i > 0; i--) begin
            key_pool[$urandom_range(0, POOL_SIZE - 1)] = fresh_key();
         end
         roll = $urandom_range(0, 9);
         if (roll <= 2) begin
            // fill, often far enough to hit a full list
            n = $urandom_range(20, 70);
            for (int i = 0; i < n; i++) begin
               add_op(CMD_APPEND, pick_key(), 1'b0, '0);
            end
         end else if (roll <= 6) begin
            n = $urandom_range(10, 40);
            for (int i = 0; i < n; i++) begin
               roll = $urandom_range(0, 99);
               if (roll < 35) begin
                  add_op(CMD_APPEND, pick_key(), 1'b0, '0);
               end else if (roll < 65) begin
                  add_op(CMD_SEARCH, pick_key(), 1'b0, '0);
               end else if (roll < 95) begin
                  add_op(CMD_DELETE, pick_key(), 1'b0, '0);
               end else begin
                  add_op(CMD_CLEAR, fresh_key(), 1'b0, '0);
               end
            end
         end else if (roll <= 8) begin
            n = $urandom_range(10, 40);
            for (int i = 0; i < n; i++) begin
               add_op(($urandom_range(0, 9) < 7) ? CMD_DELETE : CMD_SEARCH,
                      pick_key(), 1'b0, '0);
            end
         end else begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
               add_op(COMMAND_W'($urandom_range(0, 3)), $urandom, 1'b0, '0);
            end
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (accepted_items < op_plan.size() || pending_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   // sender: bursts of requests with idle gaps between them
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (send_idx < op_plan.size()) begin
            req_valid <= 1'b1;
            req_data  <= op_plan[send_idx].req;
            send_idx++;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern changes mode every so often
   always @(posedge clock) begin : stall_proc
      logic hold;
      hold = 1'b0;
      if (!reset) begin
         if (stall_left == 0) begin
            stall_mode   = $urandom_range(0, 3);
            stall_left   = $urandom_range(20, 200);
            stall_period = $urandom_range(1, 7);
            stall_phase  = 0;
         end
         stall_left--;
         case (stall_mode)
            0:       hold = 1'b0;
            1:       hold = ($urandom_range(0, 3) == 0);
            2:       hold = ($urandom_range(0, 3) != 0);
            default: hold = ((stall_phase / stall_period) % 2) == 1;
         endcase
         stall_phase++;
      end
      rsp_stall <= hold;
   end

   // scoreboard: responses first, then the request taken at this edge
   always @(posedge clock) begin : score_proc
      okl_rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected response: status %0d position %0d count %0d",
                           rsp_data.status, rsp_data.position, rsp_data.count);
               end
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.status !== want.status || rsp_data.position !== want.position ||
                   rsp_data.count !== want.count) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: expected status %0d position %0d count %0d, %s",
                              want.status, want.position, want.count, "got");
                     $display("          actual   status %0d position %0d count %0d",
                              rsp_data.status, rsp_data.position, rsp_data.count);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = list_apply(req_data);
            if (op_plan[accepted_items].fixed) begin
               want = op_plan[accepted_items].rsp;
            end
            pending_results.push_back(want);
            accepted_items++;
         end
      end
   end

endmodule

>>> ordered_key_list.f
src/okl_pkg.sv
src/okl_key_ram.sv
src/okl_seq.sv
src/ordered_key_list.sv
dv/tb_top.sv
